### rtl/core/rpm_to_timer_compare_top_macros.svh
// Assertion macros shared by the rpm-to-timer-compare RTL.
`ifndef RPM_TO_TIMER_COMPARE_TOP_MACROS_SVH
`define RPM_TO_TIMER_COMPARE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define RTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/rtc_pkg.sv
// Shared types and constants of the rpm-to-timer-compare block.
package rtc_pkg;

  // Field widths.
  localparam int RpmW     = 16;
  localparam int ScaleW   = 16;
  localparam int DenomW   = RpmW + ScaleW;
  localparam int NumerW   = 35;
  localparam int CompareW = 16;
  localparam int CodeW    = 3;

  // Tick rate times the Q4.12 unit: 8000000 * 4096.
  localparam logic [NumerW-1:0] NUMER = 35'd32768000000;

  // Requests below this speed are raised to it.
  localparam logic [RpmW-1:0] RPM_MIN = 16'd10;

  // Reset value of the scale register (1.0 in Q4.12).
  localparam logic [ScaleW-1:0] SCALE_RESET = 16'd4096;

  // Period thresholds for the prescaler choice.
  localparam logic [NumerW-1:0] LIMIT_DIV1024 = 35'd16777216;
  localparam logic [NumerW-1:0] LIMIT_DIV256  = 35'd4194304;
  localparam logic [NumerW-1:0] LIMIT_DIV64   = 35'd524288;
  localparam logic [NumerW-1:0] LIMIT_DIV8    = 35'd65536;

  // Prescaler codes.
  localparam logic [CodeW-1:0] PSC_DIV1    = 3'd0;
  localparam logic [CodeW-1:0] PSC_DIV8    = 3'd1;
  localparam logic [CodeW-1:0] PSC_DIV64   = 3'd2;
  localparam logic [CodeW-1:0] PSC_DIV256  = 3'd3;
  localparam logic [CodeW-1:0] PSC_DIV1024 = 3'd4;

  localparam logic [CompareW-1:0] COMPARE_MAX = 16'hFFFF;

  // Register map: word index of the scale register.
  localparam logic REG_RPM_SCALE = 1'b0;

  // Depth of the job queue between front and back.
  localparam int QueueDepth = 2;

  // One classified job handed from the front to the back.
  typedef struct packed {
    logic [DenomW-1:0] denom;
  } rtc_job_t;

  // One finished result.
  typedef struct packed {
    logic [CompareW-1:0] compare_value;
    logic [CodeW-1:0]    prescaler_code;
    logic                saturated;
  } rtc_result_t;

endpackage

### rtl/core/rpm_to_timer_compare_top.sv
// Top level of the rpm-to-timer-compare block with its register port.
//
// Converts a requested speed into a timer compare value and a prescaler code.
// The rpm (raised to at least 10) is multiplied by the Q4.12 scale register,
// and 8000000*4096 is divided by that product in a restoring divider that
// yields one quotient bit per cycle. Once all 35 quotient bits are in, the
// prescaler is picked and, when the result register is free, the result is
// loaded; the divider can start the next queued job in the same cycle as that
// load. A two-entry job queue lets new requests be taken while the divider is
// busy and while a finished result waits to be popped. The scale register
// sits at byte address 0, resets to 4096 (1.0) and should be written only
// while the block is idle.
module rpm_to_timer_compare_top
  import rtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [RpmW-1:0]     rpm_i,
  output logic                empty,
  input  logic                pop,
  output logic [CompareW-1:0] compare_value_o,
  output logic [CodeW-1:0]    prescaler_code_o,
  output logic                saturated_o
);

  logic [ScaleW-1:0] scale_q;
  logic              cfg_write;
  logic              front_valid;
  rtc_job_t          front_job;
  logic              queue_full;
  rtc_job_t          queue_job;
  logic              queue_empty;
  logic              queue_pop;

  // Configuration register: written in the access phase of a write transfer.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[1] == REG_RPM_SCALE);
  assign prdata    = (paddr[1] == REG_RPM_SCALE) ? {16'b0, scale_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_write) begin
      scale_q <= pwdata[ScaleW-1:0];
    end
  end

  rtc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .rpm_i       (rpm_i),
    .scale_i     (scale_q),
    .job_valid_o (front_valid),
    .job_ready_i (~queue_full),
    .job_o       (front_job)
  );

  rtc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_job),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_job),
    .empty_o (queue_empty)
  );

  rtc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_empty_i      (queue_empty),
    .job_i            (queue_job),
    .job_pop_o        (queue_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .compare_value_o  (compare_value_o),
    .prescaler_code_o (prescaler_code_o),
    .saturated_o      (saturated_o)
  );

endmodule

### rtl/core/rtc_front.sv
// Front part: accepts speed requests, clamps them and forms the divisor.
module rtc_front
  import rtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [RpmW-1:0]   rpm_i,
  input  logic [ScaleW-1:0] scale_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output rtc_job_t          job_o
);

  logic              valid_q, valid_d;
  rtc_job_t          job_q;
  logic [RpmW-1:0]   rpm_clamped;
  logic              accept;
  logic              drain;

  // The stage holds a job until the queue takes it.
  assign drain  = valid_q & job_ready_i;
  assign full_o = valid_q & ~job_ready_i;
  assign accept = push_i & ~full_o;

  // Clamp the request to the minimum speed.
  assign rpm_clamped = (rpm_i < RPM_MIN) ? RPM_MIN : rpm_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (drain) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Divisor is scale times clamped rpm; a zero scale gives a zero divisor.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.denom <= DenomW'(rpm_clamped) * DenomW'(scale_i);
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

### rtl/core/rtc_queue.sv
// Short job queue that decouples the front from the divider.
module rtc_queue
  import rtc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rtc_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output rtc_job_t data_o,
  output logic     empty_o
);

  `include "rpm_to_timer_compare_top_macros.svh"

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  rtc_job_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The fill level never passes the depth.
  `RTC_ASSERT_IMP(a_queue_level, 1'b1, count_q <= CntFull)

endmodule

### rtl/core/rtc_back.sv
// Back part: restoring divider, prescaler choice and result register.
module rtc_back
  import rtc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  rtc_job_t            job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [CompareW-1:0] compare_value_o,
  output logic [CodeW-1:0]    prescaler_code_o,
  output logic                saturated_o
);

  `include "rpm_to_timer_compare_top_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int CntW = $clog2(NumerW);
  localparam logic [CntW-1:0] CntLast = CntW'(NumerW - 1);

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DenomW-1:0]   denom_q, denom_d;
  logic [DenomW-1:0]   rem_q, rem_d;
  logic [NumerW-1:0]   quo_q, quo_d;
  logic                out_valid_q, out_valid_d;
  rtc_result_t         out_q;
  rtc_result_t         result;
  logic [DenomW:0]     rem_sh;
  logic [DenomW:0]     rem_sub;
  logic                fits;
  logic                out_free;
  logic                start;
  logic                load_out;
  logic [NumerW-1:0]   shifted;

  // One quotient bit per cycle: the numerator shifts out of the quotient
  // register into the remainder while quotient bits shift in. A zero divisor
  // gives all ones, which ends up as the saturated divide-by-1024 result.
  assign rem_sh  = {rem_q, quo_q[NumerW-1]};
  assign rem_sub = rem_sh - {1'b0, denom_q};
  assign fits    = (rem_sh >= {1'b0, denom_q});

  // Prescaler choice and shift of the finished period.
  always_comb begin
    priority if (quo_q >= LIMIT_DIV1024) begin
      result.prescaler_code = PSC_DIV1024;
      shifted               = quo_q >> 10;
    end else if (quo_q >= LIMIT_DIV256) begin
      result.prescaler_code = PSC_DIV256;
      shifted               = quo_q >> 8;
    end else if (quo_q >= LIMIT_DIV64) begin
      result.prescaler_code = PSC_DIV64;
      shifted               = quo_q >> 6;
    end else if (quo_q >= LIMIT_DIV8) begin
      result.prescaler_code = PSC_DIV8;
      shifted               = quo_q >> 3;
    end else begin
      result.prescaler_code = PSC_DIV1;
      shifted               = quo_q;
    end
    result.saturated     = |shifted[NumerW-1:CompareW];
    result.compare_value = result.saturated ? COMPARE_MAX : shifted[CompareW-1:0];
  end

  assign out_free = ~out_valid_q | pop_i;
  assign load_out = (state_q == ST_FIN) & out_free;
  assign start    = ~job_empty_i & ((state_q == ST_IDLE) | load_out);
  assign job_pop_o = start;

  // Sequencer and datapath next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    denom_d = denom_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_d = fits ? rem_sub[DenomW-1:0] : rem_sh[DenomW-1:0];
        quo_d = {quo_q[NumerW-2:0], fits};
        if (cnt_q == CntLast) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_d = start ? ST_RUN : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (start) begin
      cnt_d   = '0;
      denom_d = job_i.denom;
      rem_d   = '0;
      quo_d   = NUMER;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    denom_q <= denom_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    if (load_out) begin
      out_q <= result;
    end
  end

  assign empty_o          = ~out_valid_q;
  assign compare_value_o  = out_q.compare_value;
  assign prescaler_code_o = out_q.prescaler_code;
  assign saturated_o      = out_q.saturated;

  // The partial remainder stays below a nonzero divisor.
  `RTC_ASSERT_IMP(a_rem_below_denom, (state_q == ST_RUN) && (denom_q != '0), rem_q < denom_q)
  // A saturated result always carries the largest compare value.
  `RTC_ASSERT_IMP(a_sat_max, out_valid_q && out_q.saturated, out_q.compare_value == COMPARE_MAX)
  // A job leaves the queue only when the divider can take it.
  `RTC_ASSERT_NXT(a_start_runs, start, (state_q == ST_RUN) && (cnt_q == '0))

endmodule

### test/tb_rtc_ledger_pkg.sv
// Scoreboard class that predicts and checks rpm-to-timer-compare results.
package tb_rtc_ledger_pkg;
  import rtc_pkg::*;

  class compare_ledger;
    logic [ScaleW-1:0] scale;
    rtc_result_t       owed_results[$];
    int                errors;

    function new();
      scale  = SCALE_RESET;
      errors = 0;
    endfunction

    // Track the scale register as the testbench writes it.
    function void set_scale(logic [ScaleW-1:0] value);
      scale = value;
    endfunction

    // Print one line per mismatch and count it.
    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    // Work out the compare value, prescaler and saturation for one speed request.
    function rtc_result_t predict_compare(logic [RpmW-1:0] rpm);
      logic [RpmW-1:0]   speed;
      logic [DenomW-1:0] denom;
      logic [NumerW-1:0] period;
      logic [NumerW-1:0] shifted;
      int                shift;
      rtc_result_t       res;
      speed = (rpm < RPM_MIN) ? RPM_MIN : rpm;
      // A zero scale behaves like an endless period.
      if (scale == '0) begin
        res.compare_value  = COMPARE_MAX;
        res.prescaler_code = PSC_DIV1024;
        res.saturated      = 1'b1;
        return res;
      end
      denom  = DenomW'(speed) * DenomW'(scale);
      period = NUMER / NumerW'(denom);
      // Pick the smallest prescaler that the period calls for.
      if (period >= LIMIT_DIV1024) begin
        res.prescaler_code = PSC_DIV1024;
        shift = 10;
      end else if (period >= LIMIT_DIV256) begin
        res.prescaler_code = PSC_DIV256;
        shift = 8;
      end else if (period >= LIMIT_DIV64) begin
        res.prescaler_code = PSC_DIV64;
        shift = 6;
      end else if (period >= LIMIT_DIV8) begin
        res.prescaler_code = PSC_DIV8;
        shift = 3;
      end else begin
        res.prescaler_code = PSC_DIV1;
        shift = 0;
      end
      shifted = period >> shift;
      // Clip instead of truncating when the value still does not fit.
      if (shifted > NumerW'(COMPARE_MAX)) begin
        res.compare_value = COMPARE_MAX;
        res.saturated     = 1'b1;
      end else begin
        res.compare_value = shifted[CompareW-1:0];
        res.saturated     = 1'b0;
      end
      return res;
    endfunction

    // An accepted request owes exactly one result.
    function void note_rpm(logic [RpmW-1:0] rpm);
      owed_results.push_back(predict_compare(rpm));
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    // Compare a popped result with the oldest owed one, field by field.
    function void check_result(rtc_result_t got);
      rtc_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result value=%0d code=%0d sat=%0d",
                         got.compare_value, got.prescaler_code, got.saturated));
        return;
      end
      want = owed_results.pop_front();
      if (got.compare_value !== want.compare_value)
        report($sformatf("compare_value got %0d want %0d",
                         got.compare_value, want.compare_value));
      if (got.prescaler_code !== want.prescaler_code)
        report($sformatf("prescaler_code got %0d want %0d",
                         got.prescaler_code, want.prescaler_code));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated got %0d want %0d", got.saturated, want.saturated));
    endfunction

    // Anything still owed at the end never arrived.
    function void close_out();
      if (owed_results.size() != 0)
        report($sformatf("%0d results never arrived", owed_results.size()));
      owed_results.delete();
    endfunction
  endclass

endpackage

### test/tb_top.sv
// Top-level testbench that drives and checks the rpm-to-timer-compare block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtc_pkg::*;
  import tb_rtc_ledger_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 60;
  localparam int RandomPhases  = 6;
  localparam int PhaseItems    = 140;
  localparam logic [1:0] SCALE_ADDR = 2'(4 * REG_RPM_SCALE);

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [1:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push    = 1'b0;
  logic                full;
  logic [RpmW-1:0]     rpm_i   = '0;
  logic                empty;
  logic                pop     = 1'b0;
  logic [CompareW-1:0] compare_value_o;
  logic [CodeW-1:0]    prescaler_code_o;
  logic                saturated_o;

  rtc_result_t     seen_result;
  compare_ledger   ledger = new();
  logic [RpmW-1:0] corner_rpms[$];
  logic [15:0]     stall_pattern = 16'hFFFF;
  int              stall_left    = 0;
  int              stall_bit     = 0;
  int              idle_cycles   = 0;

  assign seen_result = {compare_value_o, prescaler_code_o, saturated_o};

  rpm_to_timer_compare_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .rpm_i            (rpm_i),
    .empty            (empty),
    .pop              (pop),
    .compare_value_o  (compare_value_o),
    .prescaler_code_o (prescaler_code_o),
    .saturated_o      (saturated_o)
  );

  // Free-running 2 ns clock.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The result side stalls on a pattern that is redrawn whenever its random run ends.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: stall_pattern = 16'hFFFF;
        1: stall_pattern = 16'($urandom) | 16'h0001;
        default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
      endcase
    end
    stall_left--;
    pop       = stall_pattern[stall_bit];
    stall_bit = (stall_bit + 1) % 16;
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) ledger.check_result(seen_result);
  end

  // Give up when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable && pready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("[rpm_to_timer_compare_top] ERROR");
      $finish;
    end
  end

  // Offer one speed request and hold it until the block takes it.
  task automatic send_rpm(logic [RpmW-1:0] value);
    @(negedge clk_i);
    push  = 1'b1;
    rpm_i = value;
    do @(posedge clk_i); while (full);
    ledger.note_rpm(value);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk_i);
    push = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until every owed result has been popped.
  task automatic drain();
    @(negedge clk_i);
    push = 1'b0;
    while (ledger.owed() != 0) @(posedge clk_i);
  endtask

  // Write the scale register on an idle block, then read it back.
  task automatic write_scale(logic [ScaleW-1:0] value);
    logic [31:0] readback;
    drain();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SCALE_ADDR;
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    ledger.set_scale(value);
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback !== 32'(value))
      ledger.report($sformatf("scale readback got %0d want %0d", readback, value));
  endtask

  // Mix of full-range, low-speed, log-spread and near-maximum requests.
  function automatic logic [RpmW-1:0] pick_rpm();
    int width;
    case ($urandom_range(0, 3))
      0: return RpmW'($urandom_range(0, 65535));
      1: return RpmW'($urandom_range(0, 20));
      2: begin
        width = $urandom_range(1, RpmW);
        return RpmW'(($urandom & ((1 << width) - 1)) | (1 << (width - 1)));
      end
      default: return RpmW'(16'hFFFF - $urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_corners();
    foreach (corner_rpms[i]) send_rpm(corner_rpms[i]);
  endtask

  // Random requests in bursts, with short and occasional long gaps.
  task automatic run_random(int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        if (sent < count) begin
          send_rpm(pick_rpm());
          sent++;
        end
      end
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      if (gap > 0) pause_sender(gap);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset scale: speed clamp, prescaler edges and bit patterns.
    corner_rpms = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd122, 16'd123,
                    16'hFFFF, 16'h5555, 16'hAAAA};
    send_corners();

    // Period of exactly 65536 and one just below it.
    write_scale(16'd8);
    corner_rpms = '{16'd62500, 16'd62501};
    send_corners();

    // Smallest scale gives the longest periods and saturation.
    write_scale(16'd1);
    corner_rpms = '{16'd10, 16'hFFFF, 16'h8000};
    send_corners();

    // A zero scale reads as an endless period.
    write_scale(16'd0);
    corner_rpms = '{16'd0, 16'hFFFF};
    send_corners();

    write_scale(16'hFFFF);
    corner_rpms = '{16'd10, 16'hFFFF, 16'd500};
    send_corners();

    // Random phases over a spread of scale settings.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: write_scale(SCALE_RESET);
        1: write_scale(16'd1);
        2: write_scale(16'hFFFF);
        3: write_scale(ScaleW'($urandom_range(1, 64)));
        default: write_scale(ScaleW'($urandom_range(1, 65535)));
      endcase
      run_random(PhaseItems);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    ledger.close_out();
    if (ledger.errors == 0)
      $display("[rpm_to_timer_compare_top] OK");
    else
      $display("[rpm_to_timer_compare_top] ERROR");
    $finish;
  end

endmodule

### rpm_to_timer_compare_top.f
+incdir+rtl/core
rtl/core/rtc_pkg.sv
rtl/core/rtc_front.sv
rtl/core/rtc_queue.sv
rtl/core/rtc_back.sv
rtl/core/rpm_to_timer_compare_top.sv
test/tb_rtc_ledger_pkg.sv
test/tb_top.sv
